[hw/rtl/mplru_pkg.sv]
// Shared types, sizes and codes for the two-level page cache map unit.
// No dependencies; every other file but mplru_ram refers to this package by scoped names.
package mplru_pkg;

    localparam int MAP_DEPTH        = 65536;
    localparam int ENTRIES_PER_PAGE = 512;
    localparam int FIRST_SLOTS      = 16;
    localparam int SECOND_SLOTS     = 64;

    localparam int LPN_W  = 16;
    localparam int WORD_W = 64;
    localparam int LAT_W  = 35;
    localparam int CFG_W  = 32;
    localparam int TP_W   = 17;
    localparam int CIDX_W = 3;

    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    // page number is the lpn with the in-page offset shifted out
    localparam int PAGE_SH   = $clog2(ENTRIES_PER_PAGE);
    localparam int PAGE_W    = LPN_W - PAGE_SH;
    localparam int MAX_SLOTS = (FIRST_SLOTS > SECOND_SLOTS) ? FIRST_SLOTS : SECOND_SLOTS;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int AGE_W     = SLOT_W;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int F_AW      = (FIRST_SLOTS > 1) ? $clog2(FIRST_SLOTS) : 1;
    localparam int S_AW      = (SECOND_SLOTS > 1) ? $clog2(SECOND_SLOTS) : 1;
    localparam int ENT_W     = PAGE_W + AGE_W;

    localparam logic [CIDX_W-1:0] CFG_ENABLE    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_TPAGES    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_FIRST_RD  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_FIRST_WR  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_SECOND_RD = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_SECOND_WR = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_BACK_RD   = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_BACK_WR   = 3'd7;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [1:0] LVL_FIRST  = 2'd0;
    localparam logic [1:0] LVL_SECOND = 2'd1;
    localparam logic [1:0] LVL_STORE  = 2'd2;
    localparam logic [1:0] LVL_BYPASS = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_MAPD,
        ST_SRCH1,
        ST_SRCH2,
        ST_UPD2,
        ST_ADD2,
        ST_UPD1,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [PAGE_W-1:0] tag;
        logic [AGE_W-1:0]  age;
    } entry_t;

    typedef struct packed {
        logic              level;   // 0 first level, 1 second level
        logic              update;  // 0 search pass, 1 age/tag update pass
        logic              install;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;    // hit slot on touch, LRU slot on full install
        logic [AGE_W-1:0]  age;
    } walk_cmd_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic [AGE_W-1:0]  hit_age;
        logic [SLOT_W-1:0] lru_slot;
        logic [AGE_W-1:0]  lru_age;
    } walk_res_t;

endpackage

[hw/rtl/mplru_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mplru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/mplru_walk.sv]
// Shared slot walker: scans one cache level a slot per cycle, either searching
// tags/LRU or rewriting ages and tags. Holds both tag RAMs and fill counts.
// Depends on mplru_pkg and mplru_ram.
module mplru_walk (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  run,
    input  mplru_pkg::walk_cmd_t  cmd,
    output logic                  done,
    output logic                  full,
    output mplru_pkg::walk_res_t  res
);

    logic [mplru_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                         pv_reg, pv_next;
    logic [mplru_pkg::SLOT_W-1:0] pidx_reg, pidx_next;
    logic [mplru_pkg::CNT_W-1:0]  fill1_reg, fill1_next, fill2_reg, fill2_next;
    logic                         hit_reg, hit_next, any_reg, any_next;
    logic [mplru_pkg::SLOT_W-1:0] hslot_reg, hslot_next, lslot_reg, lslot_next;
    logic [mplru_pkg::AGE_W-1:0]  hage_reg, hage_next, lage_reg, lage_next;

    logic [mplru_pkg::CNT_W-1:0]  n_cnt, fill_cur;
    logic [mplru_pkg::ENT_W-1:0]  rd1, rd2, wdata;
    mplru_pkg::entry_t            ent, went;
    logic                         ent_ok, take_hit, take_lru, we;
    logic [mplru_pkg::SLOT_W-1:0] tgt;
    logic [mplru_pkg::AGE_W-1:0]  thr;
    logic                         all_old;

    assign n_cnt    = cmd.level ? mplru_pkg::CNT_W'(mplru_pkg::SECOND_SLOTS)
                                : mplru_pkg::CNT_W'(mplru_pkg::FIRST_SLOTS);
    assign fill_cur = cmd.level ? fill2_reg : fill1_reg;
    assign full     = (fill_cur == n_cnt);
    assign ent      = mplru_pkg::entry_t'(cmd.level ? rd2 : rd1);
    // slots are filled in order and never emptied, so valid is slot < fill
    assign ent_ok   = pv_reg && (mplru_pkg::CNT_W'(pidx_reg) < fill_cur);
    assign done     = pv_reg && (mplru_pkg::CNT_W'(pidx_reg) == n_cnt - 1'b1);

    assign take_hit = ent_ok && !hit_reg && (ent.tag == cmd.page);
    assign take_lru = ent_ok && (!any_reg || (ent.age > lage_reg));

    always_comb begin
        res.hit      = hit_reg | take_hit;
        res.hit_slot = take_hit ? pidx_reg : hslot_reg;
        res.hit_age  = take_hit ? ent.age : hage_reg;
        res.lru_slot = take_lru ? pidx_reg : lslot_reg;
        res.lru_age  = take_lru ? ent.age : lage_reg;
    end

    // target and threshold of the update pass
    always_comb begin
        all_old = cmd.install && !full;
        tgt     = all_old ? mplru_pkg::SLOT_W'(fill_cur) : cmd.slot;
        thr     = cmd.age;
    end

    always_comb begin
        went = ent;
        we   = 1'b0;
        if (pv_reg && cmd.update) begin
            if (pidx_reg == tgt) begin
                went.tag = cmd.install ? cmd.page : ent.tag;
                went.age = '0;
                we       = 1'b1;
            end else if (ent_ok && (all_old || (ent.age < thr))) begin
                went.age = ent.age + 1'b1;
                we       = 1'b1;
            end
        end
        wdata = went;
    end

    always_comb begin
        cnt_next   = cnt_reg;
        pv_next    = 1'b0;
        pidx_next  = pidx_reg;
        fill1_next = fill1_reg;
        fill2_next = fill2_reg;
        hit_next   = res.hit;
        hslot_next = res.hit_slot;
        hage_next  = res.hit_age;
        any_next   = any_reg | take_lru;
        lslot_next = res.lru_slot;
        lage_next  = res.lru_age;
        if (run && (cnt_reg < n_cnt)) begin
            pv_next   = 1'b1;
            pidx_next = mplru_pkg::SLOT_W'(cnt_reg);
            cnt_next  = cnt_reg + 1'b1;
        end
        if (done || !run) begin
            cnt_next = '0;
            pv_next  = 1'b0;
            hit_next = 1'b0;
            any_next = 1'b0;
        end
        if (done && cmd.update && all_old) begin
            if (cmd.level) begin
                fill2_next = fill2_reg + 1'b1;
            end else begin
                fill1_next = fill1_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            pv_reg    <= 1'b0;
            fill1_reg <= '0;
            fill2_reg <= '0;
            hit_reg   <= 1'b0;
            any_reg   <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            pv_reg    <= pv_next;
            fill1_reg <= fill1_next;
            fill2_reg <= fill2_next;
            hit_reg   <= hit_next;
            any_reg   <= any_next;
        end
        pidx_reg  <= pidx_next;
        hslot_reg <= hslot_next;
        hage_reg  <= hage_next;
        lslot_reg <= lslot_next;
        lage_reg  <= lage_next;
    end

    mplru_ram #(
        .WIDTH(mplru_pkg::ENT_W),
        .DEPTH(mplru_pkg::FIRST_SLOTS)
    ) u_first_tags (
        .aclk (aclk),
        .we   (we && !cmd.level),
        .waddr(mplru_pkg::F_AW'(pidx_reg)),
        .wdata(wdata),
        .raddr(mplru_pkg::F_AW'(cnt_reg)),
        .rdata(rd1)
    );

    mplru_ram #(
        .WIDTH(mplru_pkg::ENT_W),
        .DEPTH(mplru_pkg::SECOND_SLOTS)
    ) u_second_tags (
        .aclk (aclk),
        .we   (we && cmd.level),
        .waddr(mplru_pkg::S_AW'(pidx_reg)),
        .wdata(wdata),
        .raddr(mplru_pkg::S_AW'(cnt_reg)),
        .rdata(rd2)
    );

endmodule

[hw/rtl/mapping_page_two_level_lru_cache_top.sv]
// Top level: sequencer, map store, configuration and result register.
// Depends on mplru_pkg, mplru_ram and mplru_walk.
//
//  channel | handshake         | payload
//  s_      | s_valid/s_ready   | operation, logical_page, new_mapping
//  m_      | m_valid/m_ready   | mapping_out, hit_level, latency_ns, evicted x2, range_error
//  cfg_    | cfg_we            | cfg_index, cfg_wdata
//
// After reset the map store is swept to all ones, one entry a cycle, with s_ready low.
// An out-of-range beat goes straight to the result. Cached access: each level walk
// goes through the one shared slot walker; a lookup/update runs 3 or 4 walks.
// A finished result sits in the output register while the next beat is taken.
module mapping_page_two_level_lru_cache_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [mplru_pkg::LPN_W-1:0]   s_logical_page,
    input  logic [mplru_pkg::WORD_W-1:0]  s_new_mapping,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mplru_pkg::WORD_W-1:0]  m_mapping_out,
    output logic [1:0]                    m_hit_level,
    output logic [mplru_pkg::LAT_W-1:0]   m_latency_ns,
    output logic                          m_first_evicted,
    output logic                          m_second_evicted,
    output logic                          m_range_error,
    input  logic                          cfg_we,
    input  logic [mplru_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [mplru_pkg::CFG_W-1:0]   cfg_wdata
);

    mplru_pkg::state_t state_reg, state_next;

    logic                        en_reg, en_next;
    logic [mplru_pkg::TP_W-1:0]  tp_reg, tp_next;
    logic [mplru_pkg::CFG_W-1:0] frd_reg, frd_next, fwr_reg, fwr_next;
    logic [mplru_pkg::CFG_W-1:0] srd_reg, srd_next, swr_reg, swr_next;
    logic [mplru_pkg::CFG_W-1:0] brd_reg, brd_next, bwr_reg, bwr_next;

    logic [mplru_pkg::MAP_AW-1:0] clr_reg, clr_next;
    logic                         op_reg, op_next;
    logic [mplru_pkg::LPN_W-1:0]  lpn_reg, lpn_next;
    logic [mplru_pkg::WORD_W-1:0] nw_reg, nw_next, word_reg, word_next;
    logic [mplru_pkg::LAT_W-1:0]  lat_reg, lat_next;
    logic [1:0]                   lvl_reg, lvl_next;
    logic                         ev1_reg, ev1_next, ev2_reg, ev2_next;
    logic                         rerr_reg, rerr_next;
    mplru_pkg::walk_res_t         r1_reg, r1_next, r2_reg, r2_next;

    logic                         mv_reg, mv_next;
    logic [mplru_pkg::WORD_W-1:0] mo_reg, mo_next;
    logic [1:0]                   mlvl_reg, mlvl_next;
    logic [mplru_pkg::LAT_W-1:0]  mlat_reg, mlat_next;
    logic                         mev1_reg, mev1_next, mev2_reg, mev2_next;
    logic                         merr_reg, merr_next;

    logic                         accept, range_bad, run, wdone, wfull, out_free;
    mplru_pkg::walk_cmd_t         cmd;
    mplru_pkg::walk_res_t         wres, rsel;
    logic                         map_we;
    logic [mplru_pkg::MAP_AW-1:0] map_waddr, map_raddr;
    logic [mplru_pkg::WORD_W-1:0] map_wdata, map_rdata;
    logic [mplru_pkg::CFG_W-1:0]  wmax;

    assign s_ready  = (state_reg == mplru_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !mv_reg || m_ready;
    assign range_bad = ({1'b0, s_logical_page} >= tp_reg)
                    || (32'(s_logical_page) >= mplru_pkg::MAP_DEPTH);

    assign m_valid          = mv_reg;
    assign m_mapping_out    = mo_reg;
    assign m_hit_level      = mlvl_reg;
    assign m_latency_ns     = mlat_reg;
    assign m_first_evicted  = mev1_reg;
    assign m_second_evicted = mev2_reg;
    assign m_range_error    = merr_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mplru_pkg::ST_CLEAR: begin
                if (clr_reg == mplru_pkg::MAP_AW'(mplru_pkg::MAP_DEPTH - 1)) begin
                    state_next = mplru_pkg::ST_IDLE;
                end
            end
            mplru_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = range_bad ? mplru_pkg::ST_DONE : mplru_pkg::ST_MAP;
                end
            end
            mplru_pkg::ST_MAP:  state_next = mplru_pkg::ST_MAPD;
            mplru_pkg::ST_MAPD: state_next = en_reg ? mplru_pkg::ST_SRCH1 : mplru_pkg::ST_DONE;
            mplru_pkg::ST_SRCH1: begin
                if (wdone) begin
                    state_next = mplru_pkg::ST_SRCH2;
                end
            end
            mplru_pkg::ST_SRCH2: begin
                if (wdone) begin
                    state_next = (op_reg == mplru_pkg::OP_LOOKUP && r1_reg.hit)
                               ? mplru_pkg::ST_UPD1 : mplru_pkg::ST_UPD2;
                end
            end
            mplru_pkg::ST_UPD2: begin
                if (wdone) begin
                    state_next = (op_reg == mplru_pkg::OP_LOOKUP && !r2_reg.hit)
                               ? mplru_pkg::ST_ADD2 : mplru_pkg::ST_UPD1;
                end
            end
            mplru_pkg::ST_ADD2: state_next = mplru_pkg::ST_UPD1;
            mplru_pkg::ST_UPD1: begin
                if (wdone) begin
                    state_next = mplru_pkg::ST_DONE;
                end
            end
            mplru_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = mplru_pkg::ST_IDLE;
                end
            end
            default: state_next = mplru_pkg::ST_IDLE;
        endcase
    end

    // walker command
    always_comb begin
        run = (state_reg == mplru_pkg::ST_SRCH1) || (state_reg == mplru_pkg::ST_SRCH2)
           || (state_reg == mplru_pkg::ST_UPD2)  || (state_reg == mplru_pkg::ST_UPD1);
        cmd.level   = (state_reg == mplru_pkg::ST_SRCH2) || (state_reg == mplru_pkg::ST_UPD2);
        cmd.update  = (state_reg == mplru_pkg::ST_UPD2) || (state_reg == mplru_pkg::ST_UPD1);
        rsel        = cmd.level ? r2_reg : r1_reg;
        cmd.install = !rsel.hit;
        cmd.page    = lpn_reg[mplru_pkg::LPN_W-1:mplru_pkg::PAGE_SH];
        cmd.slot    = rsel.hit ? rsel.hit_slot : rsel.lru_slot;
        cmd.age     = rsel.hit ? rsel.hit_age : rsel.lru_age;
    end

    // map store port
    always_comb begin
        map_we    = (state_reg == mplru_pkg::ST_CLEAR)
                 || (state_reg == mplru_pkg::ST_MAP && op_reg == mplru_pkg::OP_UPDATE);
        map_waddr = (state_reg == mplru_pkg::ST_CLEAR) ? clr_reg
                                                       : mplru_pkg::MAP_AW'(lpn_reg);
        map_wdata = (state_reg == mplru_pkg::ST_CLEAR) ? '1 : nw_reg;
        map_raddr = mplru_pkg::MAP_AW'(lpn_reg);
    end

    // datapath and configuration
    always_comb begin
        en_next  = en_reg;
        tp_next  = tp_reg;
        frd_next = frd_reg;
        fwr_next = fwr_reg;
        srd_next = srd_reg;
        swr_next = swr_reg;
        brd_next = brd_reg;
        bwr_next = bwr_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                mplru_pkg::CFG_ENABLE:    en_next  = cfg_wdata[0];
                mplru_pkg::CFG_TPAGES:    tp_next  = cfg_wdata[mplru_pkg::TP_W-1:0];
                mplru_pkg::CFG_FIRST_RD:  frd_next = cfg_wdata;
                mplru_pkg::CFG_FIRST_WR:  fwr_next = cfg_wdata;
                mplru_pkg::CFG_SECOND_RD: srd_next = cfg_wdata;
                mplru_pkg::CFG_SECOND_WR: swr_next = cfg_wdata;
                mplru_pkg::CFG_BACK_RD:   brd_next = cfg_wdata;
                mplru_pkg::CFG_BACK_WR:   bwr_next = cfg_wdata;
                default: ;
            endcase
        end

        clr_next  = clr_reg + 1'b1;
        op_next   = op_reg;
        lpn_next  = lpn_reg;
        nw_next   = nw_reg;
        word_next = word_reg;
        lat_next  = lat_reg;
        lvl_next  = lvl_reg;
        ev1_next  = ev1_reg;
        ev2_next  = ev2_reg;
        rerr_next = rerr_reg;
        r1_next   = r1_reg;
        r2_next   = r2_reg;
        wmax      = (fwr_reg > swr_reg) ? fwr_reg : swr_reg;

        case (state_reg)
            mplru_pkg::ST_IDLE: begin
                if (accept) begin
                    op_next   = s_operation;
                    lpn_next  = s_logical_page;
                    nw_next   = s_new_mapping;
                    word_next = '0;
                    lat_next  = '0;
                    lvl_next  = mplru_pkg::LVL_FIRST;
                    ev1_next  = 1'b0;
                    ev2_next  = 1'b0;
                    rerr_next = range_bad;
                end
            end
            mplru_pkg::ST_MAPD: begin
                word_next = (op_reg == mplru_pkg::OP_UPDATE) ? nw_reg : map_rdata;
                if (!en_reg) begin
                    lvl_next = mplru_pkg::LVL_BYPASS;
                end
            end
            mplru_pkg::ST_SRCH1: begin
                if (wdone) begin
                    r1_next  = wres;
                    lat_next = (op_reg == mplru_pkg::OP_UPDATE)
                             ? mplru_pkg::LAT_W'(wmax) : mplru_pkg::LAT_W'(frd_reg);
                end
            end
            mplru_pkg::ST_SRCH2: begin
                if (wdone) begin
                    r2_next  = wres;
                    lvl_next = r1_reg.hit ? mplru_pkg::LVL_FIRST
                             : (wres.hit ? mplru_pkg::LVL_SECOND : mplru_pkg::LVL_STORE);
                    if (op_reg == mplru_pkg::OP_UPDATE) begin
                        if (mplru_pkg::LAT_W'(bwr_reg) > lat_reg) begin
                            lat_next = mplru_pkg::LAT_W'(bwr_reg);
                        end
                    end else if (!r1_reg.hit) begin
                        lat_next = lat_reg + mplru_pkg::LAT_W'(srd_reg);
                    end
                end
            end
            mplru_pkg::ST_UPD2: begin
                if (wdone) begin
                    ev2_next = !r2_reg.hit && wfull;
                    if (op_reg == mplru_pkg::OP_LOOKUP && !r2_reg.hit) begin
                        lat_next = lat_reg + mplru_pkg::LAT_W'(brd_reg);
                    end
                end
            end
            mplru_pkg::ST_ADD2: lat_next = lat_reg + mplru_pkg::LAT_W'(swr_reg);
            mplru_pkg::ST_UPD1: begin
                if (wdone) begin
                    ev1_next = !r1_reg.hit && wfull;
                    if (op_reg == mplru_pkg::OP_LOOKUP && !r1_reg.hit) begin
                        lat_next = lat_reg + mplru_pkg::LAT_W'(fwr_reg);
                    end
                end
            end
            default: ;
        endcase
    end

    // result register
    always_comb begin
        mv_next   = mv_reg && !m_ready;
        mo_next   = mo_reg;
        mlvl_next = mlvl_reg;
        mlat_next = mlat_reg;
        mev1_next = mev1_reg;
        mev2_next = mev2_reg;
        merr_next = merr_reg;
        if (state_reg == mplru_pkg::ST_DONE && out_free) begin
            mv_next   = 1'b1;
            mo_next   = word_reg;
            mlvl_next = lvl_reg;
            mlat_next = lat_reg;
            mev1_next = ev1_reg;
            mev2_next = ev2_reg;
            merr_next = rerr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mplru_pkg::ST_CLEAR;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
            en_reg    <= 1'b0;
            tp_reg    <= mplru_pkg::TP_W'(65536);
            frd_reg   <= '0;
            fwr_reg   <= '0;
            srd_reg   <= '0;
            swr_reg   <= '0;
            brd_reg   <= '0;
            bwr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
            en_reg    <= en_next;
            tp_reg    <= tp_next;
            frd_reg   <= frd_next;
            fwr_reg   <= fwr_next;
            srd_reg   <= srd_next;
            swr_reg   <= swr_next;
            brd_reg   <= brd_next;
            bwr_reg   <= bwr_next;
        end
        op_reg   <= op_next;
        lpn_reg  <= lpn_next;
        nw_reg   <= nw_next;
        word_reg <= word_next;
        lat_reg  <= lat_next;
        lvl_reg  <= lvl_next;
        ev1_reg  <= ev1_next;
        ev2_reg  <= ev2_next;
        rerr_reg <= rerr_next;
        r1_reg   <= r1_next;
        r2_reg   <= r2_next;
        mo_reg   <= mo_next;
        mlvl_reg <= mlvl_next;
        mlat_reg <= mlat_next;
        mev1_reg <= mev1_next;
        mev2_reg <= mev2_next;
        merr_reg <= merr_next;
    end

    mplru_ram #(
        .WIDTH(mplru_pkg::WORD_W),
        .DEPTH(mplru_pkg::MAP_DEPTH)
    ) u_map_store (
        .aclk (aclk),
        .we   (map_we),
        .waddr(map_waddr),
        .wdata(map_wdata),
        .raddr(map_raddr),
        .rdata(map_rdata)
    );

    mplru_walk u_walk (
        .aclk   (aclk),
        .aresetn(aresetn),
        .run    (run),
        .cmd    (cmd),
        .done   (wdone),
        .full   (wfull),
        .res    (wres)
    );

endmodule

[tb/mapping_page_two_level_lru_cache_top_test.sv]
// Self-checking testbench for mapping_page_two_level_lru_cache_top: directed table, then random
// phases, checked by the table or by a page-cache predictor. Depends on mplru_pkg and the RTL.
`timescale 1ns / 1ps

module mapping_page_two_level_lru_cache_top_test;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_BEATS  = 150;
    localparam int NUM_PAGES    = mplru_pkg::MAP_DEPTH / mplru_pkg::ENTRIES_PER_PAGE;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] word;
        logic [1:0]  lvl;
        logic [34:0] lat;
        logic        ev1;
        logic        ev2;
        logic        rerr;
    } map_result_t;

    typedef struct {
        int          cfg_set;
        logic        op;
        logic [15:0] lpn;
        logic [63:0] word;
        bit          typed;
        map_result_t res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [15:0] s_logical_page;
    logic [63:0] s_new_mapping;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_mapping_out;
    logic [1:0]  m_hit_level;
    logic [34:0] m_latency_ns;
    logic        m_first_evicted;
    logic        m_second_evicted;
    logic        m_range_error;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;

    mapping_page_two_level_lru_cache_top uut (.*);

    // predictor state: map words, then per level tags, valid bits, ages and fill pointer
    logic [63:0]              map_word [0:mplru_pkg::MAP_DEPTH-1];
    logic [mplru_pkg::PAGE_W-1:0] pg_tag [2][64];
    bit                       pg_valid [2][64];
    int unsigned              pg_age [2][64];
    int unsigned              pg_fill [2];
    logic [31:0]              cfg_reg [8];
    logic [31:0]              cfg_next [8];

    map_result_t pending_results[$];
    stim_row_t   stim_rows[$];
    int errors, beats_sent, beats_seen, range_seen, ev1_seen, ev2_seen;
    int level_seen [4];
    int cycles;
    bit tx_burst, rx_burst;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int unsigned level_slots(int lv);
        return (lv == 0) ? mplru_pkg::FIRST_SLOTS : mplru_pkg::SECOND_SLOTS;
    endfunction

    function automatic int find_page(int lv, logic [mplru_pkg::PAGE_W-1:0] pg);
        for (int i = 0; i < level_slots(lv); i++)
            if (pg_valid[lv][i] && pg_tag[lv][i] == pg) return i;
        return -1;
    endfunction

    function automatic void promote(int lv, int idx, int unsigned old_age);
        for (int i = 0; i < level_slots(lv); i++)
            if (pg_valid[lv][i] && i != idx && pg_age[lv][i] < old_age) pg_age[lv][i]++;
        pg_age[lv][idx] = 0;
    endfunction

    // fills empty slots in order, then replaces the oldest (lowest index on a tie)
    function automatic bit install_page(int lv, logic [mplru_pkg::PAGE_W-1:0] pg);
        int unsigned n, v, best;
        bit ev;
        n = level_slots(lv);
        best = 0;
        if (pg_fill[lv] < n) begin
            v = pg_fill[lv];
            pg_fill[lv]++;
            ev = pg_valid[lv][v];
            promote(lv, v, 32'hFFFF_FFFF);
        end else begin
            v = 0;
            for (int i = 0; i < n; i++) begin
                if (pg_valid[lv][i] && pg_age[lv][i] >= best) begin
                    if (pg_age[lv][i] > best || !pg_valid[lv][v]) v = i;
                    best = pg_age[lv][i];
                end
            end
            ev = pg_valid[lv][v];
            promote(lv, v, ev ? pg_age[lv][v] : 32'hFFFF_FFFF);
        end
        pg_tag[lv][v] = pg;
        pg_valid[lv][v] = 1'b1;
        pg_age[lv][v] = 0;
        return ev;
    endfunction

    function automatic map_result_t predict_access(logic op, logic [15:0] lpn,
                                                   logic [63:0] word);
        map_result_t r;
        logic [mplru_pkg::PAGE_W-1:0] pg;
        logic [63:0] lat, wmax;
        int s1, s2;
        r = '0;
        lat = '0;
        if ({16'd0, lpn} >= cfg_reg[mplru_pkg::CFG_TPAGES]) begin
            r.rerr = 1'b1;
            return r;
        end
        if (!cfg_reg[mplru_pkg::CFG_ENABLE][0]) begin
            if (op == mplru_pkg::OP_UPDATE) map_word[lpn] = word;
            r.word = map_word[lpn];
            r.lvl = mplru_pkg::LVL_BYPASS;
            return r;
        end
        pg = lpn[15 -: mplru_pkg::PAGE_W];
        s1 = find_page(0, pg);
        s2 = find_page(1, pg);
        r.lvl = (s1 >= 0) ? mplru_pkg::LVL_FIRST :
                (s2 >= 0) ? mplru_pkg::LVL_SECOND : mplru_pkg::LVL_STORE;
        if (op == mplru_pkg::OP_LOOKUP) begin
            lat = cfg_reg[mplru_pkg::CFG_FIRST_RD];
            if (s1 >= 0) begin
                promote(0, s1, pg_age[0][s1]);
            end else begin
                lat += cfg_reg[mplru_pkg::CFG_SECOND_RD];
                if (s2 >= 0) begin
                    promote(1, s2, pg_age[1][s2]);
                end else begin
                    lat += cfg_reg[mplru_pkg::CFG_BACK_RD];
                    r.ev2 = install_page(1, pg);
                    lat += cfg_reg[mplru_pkg::CFG_SECOND_WR];
                end
                r.ev1 = install_page(0, pg);
                lat += cfg_reg[mplru_pkg::CFG_FIRST_WR];
            end
        end else begin
            if (s2 < 0) begin
                r.ev2 = install_page(1, pg);
                s2 = find_page(1, pg);
            end
            if (s1 < 0) begin
                r.ev1 = install_page(0, pg);
                s1 = find_page(0, pg);
            end
            wmax = cfg_reg[mplru_pkg::CFG_BACK_WR];
            if (cfg_reg[mplru_pkg::CFG_FIRST_WR] > wmax) wmax = cfg_reg[mplru_pkg::CFG_FIRST_WR];
            if (cfg_reg[mplru_pkg::CFG_SECOND_WR] > wmax) wmax = cfg_reg[mplru_pkg::CFG_SECOND_WR];
            lat = wmax;
            map_word[lpn] = word;
            if (s1 >= 0) promote(0, s1, pg_age[0][s1]);
            if (s2 >= 0) promote(1, s2, pg_age[1][s2]);
        end
        r.word = map_word[lpn];
        r.lat = lat[34:0];
        return r;
    endfunction

    function automatic map_result_t mk_res(logic [63:0] w, logic [1:0] l, logic [34:0] t,
                                           logic re);
        map_result_t r;
        r = '0;
        r.word = w;
        r.lvl = l;
        r.lat = t;
        r.rerr = re;
        return r;
    endfunction

    function automatic void add_row(int set, logic op, logic [15:0] lpn, logic [63:0] w,
                                    bit typed, map_result_t r);
        stim_row_t row;
        row.cfg_set = set;
        row.op = op;
        row.lpn = lpn;
        row.word = w;
        row.typed = typed;
        row.res = r;
        stim_rows.push_back(row);
    endfunction

    function automatic void set_config(int set);
        for (int i = 0; i < 8; i++) cfg_next[i] = '0;
        cfg_next[mplru_pkg::CFG_TPAGES] = 32'd65536;
        case (set)
            1: for (int i = 0; i < 8; i++)
                   if (i != mplru_pkg::CFG_TPAGES) cfg_next[i] = 32'hFFFF_FFFF;
            2: cfg_next[mplru_pkg::CFG_TPAGES] = 32'd0;
            3: begin
                cfg_next[mplru_pkg::CFG_ENABLE] = 32'd1;
                cfg_next[mplru_pkg::CFG_TPAGES] = 32'd1;
                for (int i = 2; i < 8; i++) cfg_next[i] = 32'(i * 3);
            end
            4: cfg_next[mplru_pkg::CFG_ENABLE] = 32'd1;
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] rand_latency();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_config();
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= i[2:0];
            cfg_wdata <= cfg_next[i];
            cfg_reg[i] = (i == mplru_pkg::CFG_ENABLE) ? (cfg_next[i] & 32'd1) :
                         (i == mplru_pkg::CFG_TPAGES) ? (cfg_next[i] & 32'h1FFFF) : cfg_next[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // valid stays high across back-to-back beats; lowered only for a gap or by drain
    task automatic send_beat(logic op, logic [15:0] lpn, logic [63:0] w, bit typed,
                             map_result_t r);
        int gap;
        map_result_t p;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_logical_page <= lpn;
        s_new_mapping <= w;
        do @(posedge aclk); while (!s_ready);
        p = predict_access(op, lpn, w);
        pending_results.push_back(typed ? r : p);
        beats_sent++;
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        map_result_t e;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (m_range_error) range_seen++;
            else level_seen[m_hit_level]++;
            ev1_seen += m_first_evicted;
            ev2_seen += m_second_evicted;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing outstanding");
                errors++;
            end else begin
                e = pending_results.pop_front();
                check_field("mapping_out", e.word, m_mapping_out);
                check_field("hit_level", e.lvl, m_hit_level);
                check_field("latency_ns", e.lat, m_latency_ns);
                check_field("first_evicted", e.ev1, m_first_evicted);
                check_field("second_evicted", e.ev2, m_second_evicted);
                check_field("range_error", e.rerr, m_range_error);
            end
        end
    end

    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int cur_set, ws, base, pg;
        logic op;
        logic [15:0] lpn, last_lpn;
        logic [63:0] w;
        map_result_t none;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = 1'b0;
        s_logical_page = '0;
        s_new_mapping = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cycles = 0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        none = '0;
        for (int i = 0; i < mplru_pkg::MAP_DEPTH; i++) map_word[i] = ALL_ONES;
        for (int l = 0; l < 2; l++) begin
            pg_fill[l] = 0;
            for (int i = 0; i < 64; i++) begin
                pg_valid[l][i] = 1'b0;
                pg_age[l][i] = 0;
                pg_tag[l][i] = '0;
            end
        end
        set_config(0);
        for (int i = 0; i < 8; i++) cfg_reg[i] = cfg_next[i];
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: bypass, full range
        add_row(0, mplru_pkg::OP_LOOKUP, 16'd0, 64'd0, 1,
                mk_res(ALL_ONES, mplru_pkg::LVL_BYPASS, 35'd0, 1'b0));
        add_row(0, mplru_pkg::OP_UPDATE, 16'hFFFF, 64'd0, 1,
                mk_res(64'd0, mplru_pkg::LVL_BYPASS, 35'd0, 1'b0));
        add_row(0, mplru_pkg::OP_LOOKUP, 16'hFFFF, ALL_ONES, 1,
                mk_res(64'd0, mplru_pkg::LVL_BYPASS, 35'd0, 1'b0));
        add_row(0, mplru_pkg::OP_UPDATE, 16'd0, ALL_ONES, 1,
                mk_res(ALL_ONES, mplru_pkg::LVL_BYPASS, 35'd0, 1'b0));
        add_row(0, mplru_pkg::OP_UPDATE, 16'd300, 64'hA5A5_5A5A_0F0F_F0F0, 1,
                mk_res(64'hA5A5_5A5A_0F0F_F0F0, mplru_pkg::LVL_BYPASS, 35'd0, 1'b0));
        // caches on, every latency at its maximum
        add_row(1, mplru_pkg::OP_LOOKUP, 16'd1000, 64'd0, 1,
                mk_res(ALL_ONES, mplru_pkg::LVL_STORE, 35'h4_FFFF_FFFB, 1'b0));
        add_row(1, mplru_pkg::OP_LOOKUP, 16'd1001, 64'd0, 1,
                mk_res(ALL_ONES, mplru_pkg::LVL_FIRST, 35'h0_FFFF_FFFF, 1'b0));
        add_row(1, mplru_pkg::OP_UPDATE, 16'd1002, 64'h0123_4567_89AB_CDEF, 1,
                mk_res(64'h0123_4567_89AB_CDEF, mplru_pkg::LVL_FIRST, 35'h0_FFFF_FFFF, 1'b0));
        add_row(1, mplru_pkg::OP_LOOKUP, 16'hFFFF, 64'd0, 1,
                mk_res(64'd0, mplru_pkg::LVL_STORE, 35'h4_FFFF_FFFB, 1'b0));
        add_row(1, mplru_pkg::OP_UPDATE, 16'd40000, 64'd0, 0, none);
        add_row(1, mplru_pkg::OP_LOOKUP, 16'd300, 64'd0, 0, none);
        // no valid pages at all
        add_row(2, mplru_pkg::OP_LOOKUP, 16'd0, 64'd0, 1,
                mk_res(64'd0, mplru_pkg::LVL_FIRST, 35'd0, 1'b1));
        add_row(2, mplru_pkg::OP_UPDATE, 16'hFFFF, ALL_ONES, 1,
                mk_res(64'd0, mplru_pkg::LVL_FIRST, 35'd0, 1'b1));
        // a single valid page, small latencies
        add_row(3, mplru_pkg::OP_LOOKUP, 16'd0, 64'd0, 0, none);
        add_row(3, mplru_pkg::OP_UPDATE, 16'd0, 64'hFEDC_BA98_7654_3210, 0, none);
        add_row(3, mplru_pkg::OP_LOOKUP, 16'd1, 64'd0, 1,
                mk_res(64'd0, mplru_pkg::LVL_FIRST, 35'd0, 1'b1));
        add_row(3, mplru_pkg::OP_UPDATE, 16'hFFFF, 64'd5, 1,
                mk_res(64'd0, mplru_pkg::LVL_FIRST, 35'd0, 1'b1));
        // zero latencies
        add_row(4, mplru_pkg::OP_LOOKUP, 16'hFFFF, 64'd0, 0, none);
        add_row(4, mplru_pkg::OP_UPDATE, 16'd512, ALL_ONES, 0, none);
        add_row(4, mplru_pkg::OP_LOOKUP, 16'd513, 64'd0, 0, none);

        cur_set = 0;
        foreach (stim_rows[i]) begin
            if (stim_rows[i].cfg_set != cur_set) begin
                drain();
                cur_set = stim_rows[i].cfg_set;
                set_config(cur_set);
                load_config();
            end
            send_beat(stim_rows[i].op, stim_rows[i].lpn, stim_rows[i].word,
                      stim_rows[i].typed, stim_rows[i].res);
        end

        last_lpn = '0;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            cfg_next[mplru_pkg::CFG_ENABLE] = 32'($urandom_range(0, 5) != 0);
            case ($urandom_range(0, 5))
                0: cfg_next[mplru_pkg::CFG_TPAGES] = $urandom_range(1, 65535);
                1: cfg_next[mplru_pkg::CFG_TPAGES] = 32'd1;
                default: cfg_next[mplru_pkg::CFG_TPAGES] = 32'd65536;
            endcase
            for (int i = 2; i < 8; i++) cfg_next[i] = rand_latency();
            load_config();
            tx_burst = $urandom_range(0, 3) == 0;
            // working sets from well inside to well beyond both levels
            case ($urandom_range(0, 4))
                0: ws = 4;
                1: ws = 12;
                2: ws = 20;
                3: ws = 70;
                default: ws = NUM_PAGES;
            endcase
            base = $urandom_range(0, NUM_PAGES - 1);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if ($urandom_range(0, 29) == 0) tx_burst = ~tx_burst;
                if ($urandom_range(0, 7) == 0) begin
                    lpn = last_lpn;
                end else if ($urandom_range(0, 9) == 0) begin
                    lpn = 16'($urandom_range(0, 65535));
                end else begin
                    pg = (base + $urandom_range(0, ws - 1)) % NUM_PAGES;
                    lpn = 16'(pg * mplru_pkg::ENTRIES_PER_PAGE
                              + $urandom_range(0, mplru_pkg::ENTRIES_PER_PAGE - 1));
                end
                op = 1'($urandom_range(0, 1));
                w = {$urandom, $urandom};
                send_beat(op, lpn, w, 0, none);
                last_lpn = lpn;
            end
        end

        drain();
        repeat (200) @(posedge aclk);
        $display("%0d beats sent, %0d results: %0d first, %0d second, %0d store, %0d bypass",
                 beats_sent, beats_seen, level_seen[0], level_seen[1], level_seen[2],
                 level_seen[3]);
        $display("%0d out of range, %0d first-level and %0d second-level evictions",
                 range_seen, ev1_seen, ev2_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
